// ----- rtl/tte_pkg.sv -----
// Package for the tickless timer expiry engine.
// Holds shared types, reset constants, item kinds, event codes and register indexes.
// No dependencies.
package tte_pkg;

  // Default counter width of the hardware down counter.
  localparam int unsigned CounterBitsDef = 24;

  // Configuration register indexes.
  localparam int unsigned CfgIdxBits     = 8;
  localparam logic [CfgIdxBits-1:0] RegMinReload  = 8'd0;
  localparam logic [CfgIdxBits-1:0] RegNearThresh = 8'd1;

  // Configuration reset values.
  localparam logic [24:0] MinReloadRst  = 25'd16000;
  localparam logic [15:0] NearThreshRst = 16'd128;

  // Disarmed expiry mark: largest signed 64-bit value.
  localparam logic [63:0] MarkMax = 64'h7FFF_FFFF_FFFF_FFFF;

  // Item kinds.
  localparam logic [1:0] KindTick = 2'd0;
  localparam logic [1:0] KindRead = 2'd1;
  localparam logic [1:0] KindSet  = 2'd2;

  // Event codes.
  localparam logic [1:0] EvNone    = 2'd0;
  localparam logic [1:0] EvExpired = 2'd1;
  localparam logic [1:0] EvCheck   = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [62:0] expiry_time;
  } item_t;

  typedef struct packed {
    logic [62:0] now_time;
    logic [1:0]  event_res;
  } result_t;

  // Handshake state between the input stage and the result stage.
  typedef struct packed {
    logic can_load;   // result register can take a new value this cycle
    logic advance;    // held item is processed this cycle
  } stage_ctl_t;

endpackage

// ----- rtl/tte_in_stage.sv -----
// Input register of the tickless timer expiry engine.
// Holds one accepted item until the core consumes it. Uses tte_pkg.
module tte_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tte_pkg::item_t     item_i,
  input  logic               can_load_i,
  output tte_pkg::item_t     item_o,
  output logic               advance_o
);

  logic           vld_q, vld_d;
  tte_pkg::item_t item_q;

  assign advance_o  = vld_q & can_load_i;
  assign in_ready_o = ~vld_q | can_load_i;
  assign item_o     = item_q;

  always_comb begin
    vld_d = vld_q;
    if (in_valid_i && in_ready_o) begin
      vld_d = 1'b1;
    end else if (advance_o) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

endmodule

// ----- rtl/tte_core.sv -----
// Timer state and single-pass update logic of the tickless timer expiry engine.
// Tracks time and the distance to the expiry mark incrementally. Uses tte_pkg.
module tte_core #(
  parameter int unsigned CounterBits = tte_pkg::CounterBitsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             advance_i,
  input  tte_pkg::item_t   item_i,
  input  logic [24:0]      min_reload_i,
  input  logic [15:0]      near_thresh_i,
  output tte_pkg::result_t res_o
);

  localparam logic [63:0] Span  = 64'(1) << CounterBits;
  localparam logic [63:0] Span2 = Span << 1;

  // now = time_base - down_count; diff = expiry_mark - now (both mod 2^64)
  logic [63:0]            now_q, now_d;
  logic [63:0]            diff_q, diff_d;
  logic [CounterBits-1:0] count_q, count_d;
  logic [CounterBits-1:0] reload_q, reload_d;
  logic                   pend_q, pend_d;
  logic [1:0]             ev;

  logic [63:0] dm1, dm2, dm4, dset, dset3, ddis, mr64, min_sat, r_set, r_set_m1;
  logic        wrap, run, tick_exp, tick_rep, set_near;

  always_comb begin
    dm1  = diff_q - 64'd1;
    dm2  = diff_q - 64'd2;
    dm4  = diff_q - 64'd4;
    dset = {1'b0, item_i.expiry_time} - now_q;
    dset3 = dset - 64'd3;
    ddis = (tte_pkg::MarkMax - 64'd3) - now_q;
    wrap = (count_q == '0);
    run  = wrap | pend_q;
    tick_exp = (dm1 == 64'd0) | dm1[63];
    tick_rep = ~tick_exp & (dm1 <= Span);
    set_near = dset[63] | (dset < {48'd0, near_thresh_i});

    mr64 = {39'd0, min_reload_i};
    if (mr64 == 64'd0) begin
      min_sat = 64'd1;
    end else if (mr64 > Span) begin
      min_sat = Span;
    end else begin
      min_sat = mr64;
    end

    if (dset >= Span2) begin
      r_set = Span;
    end else if (dset > Span) begin
      r_set = dset >> 1;
    end else if (dset < min_sat) begin
      r_set = min_sat;
    end else begin
      r_set = dset;
    end
    r_set_m1 = r_set - 64'd1;
  end

  always_comb begin
    now_d    = now_q;
    diff_d   = diff_q;
    count_d  = count_q;
    reload_d = reload_q;
    pend_d   = pend_q;
    ev       = tte_pkg::EvNone;
    case (item_i.kind)
      tte_pkg::KindTick: begin
        now_d  = now_q + 64'd1;
        diff_d = dm1;
        pend_d = 1'b0;
        count_d = wrap ? reload_q : count_q - CounterBits'(1);
        if (run) begin
          if (tick_exp) begin
            ev = tte_pkg::EvExpired;
          end else if (tick_rep) begin
            // reprogram with r = remaining time; time steps by 3 on top of the tick
            now_d    = now_q + 64'd4;
            diff_d   = dm4;
            count_d  = dm2[CounterBits-1:0];
            reload_d = dm2[CounterBits-1:0];
          end
        end
      end
      tte_pkg::KindSet: begin
        if (item_i.expiry_time == '0) begin
          now_d    = now_q + 64'd3;
          diff_d   = ddis;
          count_d  = '1;
          reload_d = '1;
        end else if (set_near) begin
          diff_d = dset;
          pend_d = 1'b1;
          ev     = tte_pkg::EvCheck;
        end else begin
          now_d    = now_q + 64'd3;
          diff_d   = dset3;
          count_d  = r_set_m1[CounterBits-1:0];
          reload_d = r_set_m1[CounterBits-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign res_o.now_time  = now_d[62:0];
  assign res_o.event_res = ev;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q    <= Span;
      diff_q   <= tte_pkg::MarkMax - Span;
      count_q  <= '0;
      reload_q <= '1;
      pend_q   <= 1'b0;
    end else if (advance_i) begin
      now_q    <= now_d;
      diff_q   <= diff_d;
      count_q  <= count_d;
      reload_q <= reload_d;
      pend_q   <= pend_d;
    end
  end

  // Counter never runs above its reload value.
  a_count_le_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= reload_q) else $error("down counter above reload");

  // An immediate-check request leaves a pending check behind.
  a_check_sets_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && ev == tte_pkg::EvCheck |=> pend_q) else $error("pending check lost");

  // A tick always consumes a pending check.
  a_tick_clears_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && item_i.kind == tte_pkg::KindTick |=> !pend_q)
    else $error("pending check survived a tick");

  // Expiry is only reported by a tick that ran the check.
  a_expiry_on_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev == tte_pkg::EvExpired |-> item_i.kind == tte_pkg::KindTick && run)
    else $error("expiry outside a check");

endmodule

// ----- rtl/tte_out_stage.sv -----
// Result register of the tickless timer expiry engine.
// Holds one result until the downstream side takes it. Uses tte_pkg.
module tte_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  tte_pkg::result_t   res_i,
  output logic               can_load_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tte_pkg::result_t   res_o
);

  logic             vld_q, vld_d;
  tte_pkg::result_t res_q;

  assign can_load_o  = ~vld_q | out_ready_i;
  assign out_valid_o = vld_q;
  assign res_o       = res_q;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (out_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

// ----- rtl/tickless_timer_expiry_engine.sv -----
// Top level of the tickless timer expiry engine: input register, timer core,
// result register and the two configuration registers. Uses tte_pkg.
//
// The engine models a COUNTER_BITS down counter with reload, extended to a
// 64-bit tick time. Every input transfer (tick, read, set expiry) yields exactly
// one result transfer carrying the time after the item and an event code
// (none, expiry reached, immediate check requested). Throughput is one item
// per clock while m_axis_tready is high. The input register loads on the
// input transfer and the single-pass update loads the result register from
// it once the result register has a free slot; the result is then offered
// until m_axis_tready takes it. The loop that bounds the rate is
// the timer state update: time and the distance to the expiry mark are kept as
// running registers, so each item needs one wide subtract, a few compares and
// a decrement of the chosen period before the state and result registers load.
// s_axis_tready depends combinationally on m_axis_tready through the result
// register's free slot. Configuration writes are always accepted
// (cfg_ready_o = 1); indexes other than the two registers are ignored.
// Write configuration only while no item is in flight.
module tickless_timer_expiry_engine #(
  parameter int unsigned COUNTER_BITS = tte_pkg::CounterBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input item
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [62:0] expiry_time, [63] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] kind
  // result item
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [62:0] now_time, [64:63] event_res, [71:65] zero
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [tte_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  logic [24:0] cfg_data_i
);

  tte_pkg::item_t     item_in, item_held;
  tte_pkg::result_t   res_core, res_out;
  tte_pkg::stage_ctl_t ctl;

  logic [24:0] min_reload_q;
  logic [15:0] near_thresh_q;

  assign item_in.kind        = s_axis_tuser;
  assign item_in.expiry_time = s_axis_tdata[62:0];

  // Config registers; writes always accepted.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_reload_q  <= tte_pkg::MinReloadRst;
      near_thresh_q <= tte_pkg::NearThreshRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        tte_pkg::RegMinReload:  min_reload_q  <= cfg_data_i;
        tte_pkg::RegNearThresh: near_thresh_q <= cfg_data_i[15:0];
        default: begin
        end
      endcase
    end
  end

  tte_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .item_i     (item_in),
    .can_load_i (ctl.can_load),
    .item_o     (item_held),
    .advance_o  (ctl.advance)
  );

  tte_core #(
    .CounterBits (COUNTER_BITS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .advance_i     (ctl.advance),
    .item_i        (item_held),
    .min_reload_i  (min_reload_q),
    .near_thresh_i (near_thresh_q),
    .res_o         (res_core)
  );

  tte_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (ctl.advance),
    .res_i       (res_core),
    .can_load_o  (ctl.can_load),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .res_o       (res_out)
  );

  assign m_axis_tdata = {7'd0, res_out.event_res, res_out.now_time};

endmodule
